// ===== hw/rtl/p2s16_pkg.sv =====
// ----------------------------------------------------------------------------
// p2s16_pkg
// shared types and constants of the pcm to stereo int16 converter
// ----------------------------------------------------------------------------
package p2s16_pkg;

  localparam int WORD_W     = 32;
  localparam int SAMPLE_W   = 16;
  localparam int CNT_W      = 4;
  localparam int CFG_DATA_W = 4;
  localparam int SIG_W      = 24;
  localparam int PROD_W     = 39;
  localparam int EXP_W      = 8;

  localparam logic [SAMPLE_W-1:0] FULL_SCALE = 16'd32767;
  localparam logic [30:0]         MAG_INF    = 31'h7F800000;
  localparam logic [30:0]         MAG_ONE    = 31'h3F800000;
  localparam logic [EXP_W-1:0]    SHIFT_BASE = 8'd135;
  localparam logic [5:0]          SHIFT_OUT  = 6'd25;

  localparam logic REG_SAMPLE_KIND   = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  typedef enum logic [1:0] {
    KIND_FLOAT32 = 2'd0,
    KIND_INT16   = 2'd1,
    KIND_INT32   = 2'd2,
    KIND_NONE    = 2'd3
  } sample_kind_e;

  typedef enum logic [1:0] {
    CLS_ZERO   = 2'd0,
    CLS_DIRECT = 2'd1,
    CLS_FULL   = 2'd2,
    CLS_FLOAT  = 2'd3
  } value_class_e;

  typedef struct packed {
    logic [WORD_W-1:0] sample_word;
    logic              first_of_packet;
    logic              silent;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
  } out_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] sample_word;
    logic              is_left;
    logic              emit;
    logic              silent;
  } entry_t;

  typedef struct packed {
    value_class_e        cls;
    logic                neg;
    logic [SAMPLE_W-1:0] direct;
    logic [PROD_W-1:0]   prod;
    logic [EXP_W-1:0]    ex;
    logic                is_left;
    logic                emit;
    logic                silent;
  } stage_t;

endpackage

// ===== hw/rtl/p2s16_stream_if.sv =====
// ----------------------------------------------------------------------------
// p2s16_stream_if
// valid/ready channel carrying one item of type T
// ----------------------------------------------------------------------------
interface p2s16_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/pcm_to_stereo16_converter_unit.sv =====
// path: a frame-closing sample goes through the queue entry, s1_q and out_q to out_o
// throughput: one channel sample per cycle while out_o is ready, set by the front and
//   the two-stage conversion pipeline behind a two-entry queue
// reset: channel position, held left and silent flag clear, sample_kind
//   returns to int16 and channel_count to two
// ----------------------------------------------------------------------------
// pcm_to_stereo16_converter_unit
// interleaved pcm channel samples in, one signed 16-bit stereo pair per frame out
// ----------------------------------------------------------------------------
module pcm_to_stereo16_converter_unit
  import p2s16_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  p2s16_stream_if.sink          in_i,
  p2s16_stream_if.source        out_o
);

  sample_kind_e     kind_q;
  logic [CNT_W-1:0] count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= KIND_INT16;
      count_q <= CNT_W'(2);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SAMPLE_KIND:   kind_q  <= sample_kind_e'(cfg_data_i[1:0]);
        REG_CHANNEL_COUNT: count_q <= cfg_data_i[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  p2s16_stream_if #(.T(entry_t)) front_q ();
  p2s16_stream_if #(.T(entry_t)) queue_b ();

  p2s16_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .count_i (count_q),
    .in_i    (in_i),
    .out_o   (front_q)
  );

  p2s16_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (front_q),
    .out_o  (queue_b)
  );

  p2s16_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .kind_i (kind_q),
    .in_i   (queue_b),
    .out_o  (out_o)
  );

endmodule

// ===== hw/rtl/p2s16_front.sv =====
// ----------------------------------------------------------------------------
// p2s16_front
// tracks the channel position and tags each item as left, pair or ignored
// ----------------------------------------------------------------------------
module p2s16_front
  import p2s16_pkg::*;
#(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [CNT_W-1:0]    count_i,
  p2s16_stream_if.sink        in_i,
  p2s16_stream_if.source      out_o
);

  localparam int PW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int NW = CNT_W + 1;

  logic [PW-1:0] pos_q, pos_d;
  logic [NW-1:0] n_raw, n_eff, pos, nxt;
  logic          is_left, emit, accept;

  always_comb begin
    n_raw = (count_i == '0) ? NW'(2) : NW'(count_i);
    n_eff = (n_raw > NW'(MAX_CHANNELS)) ? NW'(MAX_CHANNELS) : n_raw;
    pos   = in_i.data.first_of_packet ? '0 : NW'(pos_q);
    if (pos >= n_eff) begin
      pos = '0;
    end
    is_left = (pos == '0);
    emit    = (pos == NW'(1)) || (is_left && (n_eff == NW'(1)));
    nxt     = pos + NW'(1);
    pos_d   = (nxt >= n_eff) ? '0 : nxt[PW-1:0];
  end

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = out_o.ready;

  assign out_o.valid            = in_i.valid && (is_left || emit);
  assign out_o.data.sample_word = in_i.data.sample_word;
  assign out_o.data.is_left     = is_left;
  assign out_o.data.emit        = emit;
  assign out_o.data.silent      = in_i.data.silent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

endmodule

// ===== hw/rtl/p2s16_queue.sv =====
// ----------------------------------------------------------------------------
// p2s16_queue
// two-entry queue between the front and the conversion back end
// ----------------------------------------------------------------------------
module p2s16_queue
  import p2s16_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  p2s16_stream_if.sink   in_i,
  p2s16_stream_if.source out_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_i.ready  = (cnt_q != 2'd2);
  assign out_o.valid = (cnt_q != 2'd0);
  assign out_o.data  = mem_q[rd_ptr_q];

  assign push = in_i.valid && in_i.ready;
  assign pop  = out_o.valid && out_o.ready;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.data;
    end
  end

endmodule

// ===== hw/rtl/p2s16_back.sv =====
// ----------------------------------------------------------------------------
// p2s16_back
// converts samples in two stages, holds left and assembles the stereo pair
// ----------------------------------------------------------------------------
module p2s16_back
  import p2s16_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  sample_kind_e   kind_i,
  p2s16_stream_if.sink   in_i,
  p2s16_stream_if.source out_o
);

  stage_t              s1_q, s1_d;
  logic                s1_v_q;
  out_item_t           out_q, pair;
  logic                out_v_q;
  logic [SAMPLE_W-1:0] held_q;
  logic                frame_sil_q;

  logic                s1_adv, s1_free, s1_load, out_load_ok;

  // stage 1 decode and multiply
  logic [30:0]         mag;
  logic [SIG_W-1:0]    sig;

  always_comb begin
    mag          = in_i.data.sample_word[30:0];
    sig          = {1'b1, in_i.data.sample_word[22:0]};
    s1_d         = '0;
    s1_d.neg     = in_i.data.sample_word[31];
    s1_d.ex      = in_i.data.sample_word[30:23];
    s1_d.is_left = in_i.data.is_left;
    s1_d.emit    = in_i.data.emit;
    s1_d.silent  = in_i.data.silent;
    s1_d.prod    = PROD_W'(sig) * PROD_W'(FULL_SCALE);
    case (kind_i)
      KIND_FLOAT32: begin
        if (mag > MAG_INF) begin
          s1_d.cls = CLS_ZERO;
        end else if (mag >= MAG_ONE) begin
          s1_d.cls = CLS_FULL;
        end else if (s1_d.ex == '0) begin
          s1_d.cls = CLS_ZERO;
        end else begin
          s1_d.cls = CLS_FLOAT;
        end
      end
      KIND_INT16: begin
        s1_d.cls    = CLS_DIRECT;
        s1_d.direct = in_i.data.sample_word[15:0];
      end
      KIND_INT32: begin
        s1_d.cls    = CLS_DIRECT;
        s1_d.direct = in_i.data.sample_word[31:16];
      end
      default: begin
        s1_d.cls = CLS_ZERO;
      end
    endcase
  end

  // stage 2 normalize, round, scale and sign
  logic [PROD_W-1:0]   p_norm;
  logic                round_up;
  logic [SIG_W:0]      q;
  logic [EXP_W-1:0]    amt;
  logic [SIG_W:0]      shifted;
  logic [SAMPLE_W:0]   r_wide;
  logic [SAMPLE_W-1:0] r_mag, v;

  always_comb begin
    p_norm   = s1_q.prod[PROD_W-1] ? s1_q.prod : {s1_q.prod[PROD_W-2:0], 1'b0};
    round_up = p_norm[14] && ((|p_norm[13:0]) || p_norm[15]);
    q        = {1'b0, p_norm[PROD_W-1:15]} + (SIG_W+1)'(round_up);
    amt      = SHIFT_BASE - s1_q.ex + EXP_W'(!s1_q.prod[PROD_W-1]);
    shifted  = (amt >= EXP_W'(SHIFT_OUT)) ? '0 : (q >> amt[4:0]);
    r_wide   = shifted[SAMPLE_W:0];
    r_mag    = (r_wide > (SAMPLE_W+1)'(FULL_SCALE)) ? FULL_SCALE : r_wide[SAMPLE_W-1:0];
    case (s1_q.cls)
      CLS_DIRECT: v = s1_q.direct;
      CLS_FULL:   v = s1_q.neg ? (~FULL_SCALE + 16'd1) : FULL_SCALE;
      CLS_FLOAT:  v = s1_q.neg ? (~r_mag + 16'd1) : r_mag;
      default:    v = '0;
    endcase
  end

  // pair assembly
  logic mono, zero_pair;

  always_comb begin
    mono      = s1_q.is_left && s1_q.emit;
    zero_pair = mono ? s1_q.silent : (frame_sil_q || s1_q.silent);
    if (zero_pair) begin
      pair.left_sample  = '0;
      pair.right_sample = '0;
    end else begin
      pair.left_sample  = mono ? v : held_q;
      pair.right_sample = v;
    end
  end

  assign out_load_ok = !out_v_q || out_o.ready;
  assign s1_adv      = s1_v_q && (!s1_q.emit || out_load_ok);
  assign s1_free     = !s1_v_q || s1_adv;
  assign s1_load     = in_i.valid && s1_free;

  assign in_i.ready  = s1_free;
  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      held_q      <= '0;
      frame_sil_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv && s1_q.emit) begin
        out_v_q <= 1'b1;
      end else if (out_o.ready) begin
        out_v_q <= 1'b0;
      end
      if (s1_adv && s1_q.is_left) begin
        held_q      <= v;
        frame_sil_q <= s1_q.silent;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_q <= s1_d;
    end
    if (s1_adv && s1_q.emit) begin
      out_q <= pair;
    end
  end

endmodule
